FILE: hdl/cdta_pkg.sv
package cdta_pkg;

  localparam int DIVW = 48;
  localparam int CNTW = 6;
  localparam int DVSW = 17;

  localparam logic [13:0] MAX_YEAR_RESET = 14'd9999;
  localparam logic [16:0] SEC_PER_DAY    = 17'd86400;
  localparam logic [16:0] SEC_PER_HOUR   = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN    = 17'd60;
  localparam logic [16:0] DAYS_PER_YEAR  = 17'd365;
  localparam logic [16:0] MONTHS         = 17'd12;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_LOAD    = 3'd0;
  localparam kind_t KIND_SECONDS = 3'd1;
  localparam kind_t KIND_MINUTES = 3'd2;
  localparam kind_t KIND_HOURS   = 3'd3;
  localparam kind_t KIND_DAYS    = 3'd4;
  localparam kind_t KIND_MONTHS  = 3'd5;
  localparam kind_t KIND_YEARS   = 3'd6;
  localparam kind_t KIND_SPAN    = 3'd7;

  typedef struct packed {
    logic            start;
    logic [DIVW-1:0] dividend;
    logic [DVSW-1:0] divisor;
    logic [CNTW-1:0] count;
  } div_req_t;

  // month index 0..11
  function automatic logic [4:0] month_len(input logic [3:0] idx);
    logic [4:0] len;
    case (idx)
      4'd1:    len = 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] st;
    case (idx)
      4'd0:    st = 9'd0;
      4'd1:    st = 9'd31;
      4'd2:    st = 9'd59;
      4'd3:    st = 9'd90;
      4'd4:    st = 9'd120;
      4'd5:    st = 9'd151;
      4'd6:    st = 9'd181;
      4'd7:    st = 9'd212;
      4'd8:    st = 9'd243;
      4'd9:    st = 9'd273;
      4'd10:   st = 9'd304;
      4'd11:   st = 9'd334;
      default: st = 9'd0;
    endcase
    return st;
  endfunction

  // out-of-range months map to january
  function automatic logic [3:0] month_idx(input logic [3:0] month);
    logic [3:0] idx;
    if (month >= 4'd1 && month <= 4'd12) begin
      idx = month - 4'd1;
    end else begin
      idx = 4'd0;
    end
    return idx;
  endfunction

  // month index holding a 0-based day of year
  function automatic logic [3:0] month_of(input logic [8:0] doy);
    logic [3:0] m;
    m = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy >= month_start(4'(k))) begin
        m = m + 4'd1;
      end
    end
    return m;
  endfunction

  function automatic logic [8:0] day_of_year(input logic [3:0] month, input logic [4:0] day);
    return month_start(month_idx(month)) + 9'(day) - 9'd1;
  endfunction

  function automatic logic [16:0] time_of_day(input logic [4:0] h, input logic [5:0] mi,
                                               input logic [5:0] s);
    return 17'(h) * SEC_PER_HOUR + 17'(mi) * SEC_PER_MIN + 17'(s);
  endfunction

endpackage

FILE: hdl/cdta_div.sv
module cdta_div (
  input  logic                      clk,
  input  logic                      rst,
  input  cdta_pkg::div_req_t        req,
  output logic                      done,
  output logic [cdta_pkg::DIVW-1:0] quotient,
  output logic [cdta_pkg::DVSW-1:0] remainder
);

  logic [cdta_pkg::DIVW-1:0] dividend;
  logic [cdta_pkg::DVSW-1:0] divisor;
  logic [cdta_pkg::CNTW-1:0] cnt;
  logic [cdta_pkg::DVSW:0]   trial;
  logic [cdta_pkg::DVSW:0]   diff;

  // one restoring step per cycle, dividend msb first
  assign trial = {remainder, dividend[cdta_pkg::DIVW-1]};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt       <= req.count;
      dividend  <= req.dividend;
      divisor   <= req.divisor;
      quotient  <= '0;
      remainder <= '0;
      done      <= 1'b0;
    end else if (cnt != '0) begin
      cnt      <= cnt - 1'b1;
      dividend <= {dividend[cdta_pkg::DIVW-2:0], 1'b0};
      if (!diff[cdta_pkg::DVSW]) begin
        remainder <= diff[cdta_pkg::DVSW-1:0];
        quotient  <= {quotient[cdta_pkg::DIVW-2:0], 1'b1};
      end else begin
        remainder <= trial[cdta_pkg::DVSW-1:0];
        quotient  <= {quotient[cdta_pkg::DIVW-2:0], 1'b0};
      end
      done <= (cnt == cdta_pkg::CNTW'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

FILE: hdl/cdta_check.sv
module cdta_check (
  input  logic [13:0] max_year,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  input  logic [4:0]  hour,
  input  logic [5:0]  minute,
  input  logic [5:0]  second,
  output logic        ok
);

  logic month_ok;

  assign month_ok = (month >= 4'd1) && (month <= 4'd12);

  always_comb begin
    ok = (year != '0) && (year <= max_year) && month_ok && (day != '0)
         && (day <= cdta_pkg::month_len(cdta_pkg::month_idx(month)))
         && (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60);
  end

endmodule

FILE: hdl/calendar_date_time_arithmetic_top.sv
// Calendar date and time keeper with a fixed 365-day year (no leap years). Each input
// transaction is one request selected by kind: load a moment, add seconds, minutes,
// hours, days, months or years with full carry, or measure the seconds from the stored
// moment to a later target. Exactly one output transaction follows each request; it
// carries the stored moment after the request, the span for a measure, and an error flag
// for a rejected request (stored moment untouched). Requests are handled one at a time.
// A bit-serial divider retires one quotient bit per clock. Add seconds, minutes or hours
// runs divisions by 86400, 365, 3600 and 60 back to back, add days one by 365 and add
// months one by 12; load, add years and measure use no division. A stalled output holds
// the result back. A finished result sits in an output register, so the next request
// is taken while it waits. max_year is written through the cfg channel, which is always
// ready; write it only while the block is idle.
module calendar_date_time_arithmetic_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [31:0] amount,
  input  logic [13:0] given_year,
  input  logic [3:0]  given_month,
  input  logic [4:0]  given_day,
  input  logic [4:0]  given_hour,
  input  logic [5:0]  given_minute,
  input  logic [5:0]  given_second,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [39:0] span_seconds,
  output logic        error,
  // max_year register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [13:0] cfg_data
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PREP     = 4'd1;
  localparam logic [3:0] ST_EXEC     = 4'd2;
  localparam logic [3:0] ST_DIV_DAY  = 4'd3;
  localparam logic [3:0] ST_DIV_YEAR = 4'd4;
  localparam logic [3:0] ST_DIV_HOUR = 4'd5;
  localparam logic [3:0] ST_DIV_MIN  = 4'd6;
  localparam logic [3:0] ST_DIV_MON  = 4'd7;
  localparam logic [3:0] ST_MUL      = 4'd8;
  localparam logic [3:0] ST_CMP      = 4'd9;
  localparam logic [3:0] ST_FIN      = 4'd10;

  logic [3:0]  state;
  logic [13:0] max_year;

  // stored moment
  logic [13:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic [4:0]  cur_hour;
  logic [5:0]  cur_minute;
  logic [5:0]  cur_second;

  // captured request
  cdta_pkg::kind_t kind_r;
  logic [31:0] amount_r;
  logic [13:0] gy;
  logic [3:0]  gmo;
  logic [4:0]  gd;
  logic [4:0]  gh;
  logic [5:0]  gmi;
  logic [5:0]  gs;

  // working registers
  logic [16:0] todc;
  logic [16:0] todg;
  logic [8:0]  doyc;
  logic [8:0]  doyg;
  logic [43:0] prod;
  logic        gok;
  logic [16:0] ntod;
  logic [13:0] ny;
  logic [8:0]  ndoy;
  logic [4:0]  nhour;
  logic [22:0] da;
  logic [22:0] db;
  logic [39:0] sa;
  logic [39:0] sb;
  logic [39:0] span_r;
  logic        err_r;

  // divider
  cdta_pkg::div_req_t           div_req;
  logic                         div_done;
  logic [cdta_pkg::DIVW-1:0]    div_q;
  logic [cdta_pkg::DVSW-1:0]    div_rem;
  logic                         div_start_next;

  logic        given_ok;
  logic [44:0] t_sum;
  logic [32:0] total_days;
  logic [32:0] total_mon;
  logic [33:0] y_div;
  logic [33:0] y_years;
  logic [3:0]  mon_new;
  logic [4:0]  len_new;
  logic [3:0]  mi_yday;

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  cdta_check u_check (
    .max_year (max_year),
    .year     (gy),
    .month    (gmo),
    .day      (gd),
    .hour     (gh),
    .minute   (gmi),
    .second   (gs),
    .ok       (given_ok)
  );

  cdta_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // datapath terms used by the sequencer
  assign t_sum      = 45'(todc) + 45'(prod);
  assign total_days = (state == ST_DIV_DAY) ? 33'(doyc) + 33'(div_q[28:0])
                                            : 33'(doyc) + 33'(amount_r);
  assign total_mon  = 33'(cdta_pkg::month_idx(cur_month)) + 33'(amount_r);
  assign y_div      = 34'(cur_year) + div_q[33:0];
  assign y_years    = 34'(cur_year) + 34'(amount_r);
  assign mon_new    = div_rem[3:0];
  assign len_new    = cdta_pkg::month_len(mon_new);
  // month of the day of year that the year division left behind
  assign mi_yday    = cdta_pkg::month_of(div_rem[8:0]);

  // divider launch, one pulse whenever the sequencer sets up a division
  always_comb begin
    case (state)
      ST_EXEC: begin
        div_start_next = (kind_r == cdta_pkg::KIND_SECONDS)
                         || (kind_r == cdta_pkg::KIND_MINUTES)
                         || (kind_r == cdta_pkg::KIND_HOURS)
                         || (kind_r == cdta_pkg::KIND_DAYS)
                         || (kind_r == cdta_pkg::KIND_MONTHS);
      end
      ST_DIV_DAY, ST_DIV_HOUR: begin
        div_start_next = div_done;
      end
      ST_DIV_YEAR: begin
        // time of day still to split after a seconds, minutes or hours add
        div_start_next = div_done && (y_div <= 34'(max_year))
                         && (kind_r != cdta_pkg::KIND_DAYS);
      end
      default: begin
        div_start_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      max_year      <= cdta_pkg::MAX_YEAR_RESET;
      cur_year      <= 14'd1;
      cur_month     <= 4'd1;
      cur_day       <= 5'd1;
      cur_hour      <= '0;
      cur_minute    <= '0;
      cur_second    <= '0;
      out_valid     <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      div_req.start <= div_start_next;
      if (cfg_valid && cfg_ready) begin
        max_year <= cfg_data;
      end
      // in ST_FIN the handover below decides out_valid
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r   <= kind;
            amount_r <= amount;
            gy       <= given_year;
            gmo      <= given_month;
            gd       <= given_day;
            gh       <= given_hour;
            gmi      <= given_minute;
            gs       <= given_second;
            span_r   <= '0;
            err_r    <= 1'b0;
            state    <= ST_PREP;
          end
        end

        ST_PREP: begin
          todc <= cdta_pkg::time_of_day(cur_hour, cur_minute, cur_second);
          todg <= cdta_pkg::time_of_day(gh, gmi, gs);
          doyc <= cdta_pkg::day_of_year(cur_month, cur_day);
          doyg <= cdta_pkg::day_of_year(gmo, gd);
          gok  <= given_ok;
          case (kind_r)
            cdta_pkg::KIND_MINUTES: prod <= 44'(amount_r) * 44'(cdta_pkg::SEC_PER_MIN);
            cdta_pkg::KIND_HOURS:   prod <= 44'(amount_r) * 44'(cdta_pkg::SEC_PER_HOUR);
            default:                prod <= 44'(amount_r);
          endcase
          state <= ST_EXEC;
        end

        ST_EXEC: begin
          case (kind_r)
            cdta_pkg::KIND_LOAD: begin
              if (gok) begin
                cur_year   <= gy;
                cur_month  <= gmo;
                cur_day    <= gd;
                cur_hour   <= gh;
                cur_minute <= gmi;
                cur_second <= gs;
              end else begin
                err_r <= 1'b1;
              end
              state <= ST_FIN;
            end
            cdta_pkg::KIND_SECONDS, cdta_pkg::KIND_MINUTES, cdta_pkg::KIND_HOURS: begin
              // whole days and new time of day
              div_req.dividend <= {t_sum, 3'b0};
              div_req.divisor  <= cdta_pkg::SEC_PER_DAY;
              div_req.count    <= 6'd45;
              state            <= ST_DIV_DAY;
            end
            cdta_pkg::KIND_DAYS: begin
              div_req.dividend <= {total_days, 15'b0};
              div_req.divisor  <= cdta_pkg::DAYS_PER_YEAR;
              div_req.count    <= 6'd33;
              state            <= ST_DIV_YEAR;
            end
            cdta_pkg::KIND_MONTHS: begin
              div_req.dividend <= {total_mon, 15'b0};
              div_req.divisor  <= cdta_pkg::MONTHS;
              div_req.count    <= 6'd33;
              state            <= ST_DIV_MON;
            end
            cdta_pkg::KIND_YEARS: begin
              // month stays, so the day needs no clamp
              if (y_years > 34'(max_year)) begin
                err_r <= 1'b1;
              end else begin
                cur_year <= y_years[13:0];
              end
              state <= ST_FIN;
            end
            default: begin
              if (gok) begin
                da    <= 23'(cur_year) * 23'(cdta_pkg::DAYS_PER_YEAR) + 23'(doyc);
                db    <= 23'(gy) * 23'(cdta_pkg::DAYS_PER_YEAR) + 23'(doyg);
                state <= ST_MUL;
              end else begin
                err_r <= 1'b1;
                state <= ST_FIN;
              end
            end
          endcase
        end

        ST_DIV_DAY: begin
          if (div_done) begin
            ntod             <= div_rem;
            div_req.dividend <= {total_days, 15'b0};
            div_req.divisor  <= cdta_pkg::DAYS_PER_YEAR;
            div_req.count    <= 6'd33;
            state            <= ST_DIV_YEAR;
          end
        end

        ST_DIV_YEAR: begin
          if (div_done) begin
            if (y_div > 34'(max_year)) begin
              err_r <= 1'b1;
              state <= ST_FIN;
            end else if (kind_r == cdta_pkg::KIND_DAYS) begin
              // time of day unchanged
              cur_year  <= y_div[13:0];
              cur_month <= mi_yday + 4'd1;
              cur_day   <= 5'(div_rem[8:0] - cdta_pkg::month_start(mi_yday)) + 5'd1;
              state     <= ST_FIN;
            end else begin
              ny               <= y_div[13:0];
              ndoy             <= div_rem[8:0];
              div_req.dividend <= {ntod, 31'b0};
              div_req.divisor  <= cdta_pkg::SEC_PER_HOUR;
              div_req.count    <= 6'd17;
              state            <= ST_DIV_HOUR;
            end
          end
        end

        ST_DIV_HOUR: begin
          if (div_done) begin
            nhour            <= div_q[4:0];
            div_req.dividend <= {div_rem[11:0], 36'b0};
            div_req.divisor  <= cdta_pkg::SEC_PER_MIN;
            div_req.count    <= 6'd12;
            state            <= ST_DIV_MIN;
          end
        end

        ST_DIV_MIN: begin
          if (div_done) begin
            cur_year   <= ny;
            cur_month  <= cdta_pkg::month_of(ndoy) + 4'd1;
            cur_day    <= 5'(ndoy - cdta_pkg::month_start(cdta_pkg::month_of(ndoy))) + 5'd1;
            cur_hour   <= nhour;
            cur_minute <= div_q[5:0];
            cur_second <= div_rem[5:0];
            state      <= ST_FIN;
          end
        end

        ST_DIV_MON: begin
          if (div_done) begin
            if (y_div > 34'(max_year)) begin
              err_r <= 1'b1;
            end else begin
              cur_year  <= y_div[13:0];
              cur_month <= mon_new + 4'd1;
              if (cur_day > len_new) begin
                cur_day <= len_new;
              end
            end
            state <= ST_FIN;
          end
        end

        ST_MUL: begin
          sa    <= 40'(da) * 40'(cdta_pkg::SEC_PER_DAY) + 40'(todc);
          sb    <= 40'(db) * 40'(cdta_pkg::SEC_PER_DAY) + 40'(todg);
          state <= ST_CMP;
        end

        ST_CMP: begin
          // earlier target is rejected
          if (sb < sa) begin
            err_r <= 1'b1;
          end else begin
            span_r <= sb - sa;
          end
          state <= ST_FIN;
        end

        ST_FIN: begin
          // hand over once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            out_year     <= cur_year;
            out_month    <= cur_month;
            out_day      <= cur_day;
            out_hour     <= cur_hour;
            out_minute   <= cur_minute;
            out_second   <= cur_second;
            span_seconds <= span_r;
            error        <= err_r;
            state        <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sim/tb_calendar_date_time_arithmetic_top.sv
`timescale 1ns / 1ps

module tb_calendar_date_time_arithmetic_top;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          RANDOM_ITEMS = 1800;

  typedef struct {
    cdta_pkg::kind_t kind;
    logic [31:0] amount;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } request_t;

  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [39:0] span;
    logic        err;
  } moment_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [31:0] amount;
  logic [13:0] given_year;
  logic [3:0]  given_month;
  logic [4:0]  given_day;
  logic [4:0]  given_hour;
  logic [5:0]  given_minute;
  logic [5:0]  given_second;
  logic        out_valid;
  logic        out_stall;
  logic [13:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [39:0] span_seconds;
  logic        error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [13:0] cfg_data;

  calendar_date_time_arithmetic_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .amount       (amount),
    .given_year   (given_year),
    .given_month  (given_month),
    .given_day    (given_day),
    .given_hour   (given_hour),
    .given_minute (given_minute),
    .given_second (given_second),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_year     (out_year),
    .out_month    (out_month),
    .out_day      (out_day),
    .out_hour     (out_hour),
    .out_minute   (out_minute),
    .out_second   (out_second),
    .span_seconds (span_seconds),
    .error        (error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // calendar predictor state, mirrors the stored moment and the year limit
  logic [13:0] cal_max_year;
  int unsigned cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second;

  request_t       pending_requests[$];
  moment_result_t expected_moments[$];

  int unsigned cycle_count;
  int          error_count;
  int          results_seen;
  int          errors_seen;
  int          spans_seen;
  int          kind_hits[8];
  bit          idle_free;     // long stretch with no idling on either side
  bit          hold_results;  // receiver hold-off for back pressure
  int          hold_cycles;
  bit          hold_request;

  // fixed-length calendar tables
  function automatic int unsigned days_in_month(int unsigned idx);
    case (idx)
      1:           return 28;
      3, 5, 8, 10: return 30;
      default:     return 31;
    endcase
  endfunction

  function automatic int unsigned first_day_of(int unsigned idx);
    int unsigned acc;
    acc = 0;
    for (int unsigned k = 0; k < idx; k++) acc += days_in_month(k);
    return acc;
  endfunction

  function automatic bit moment_valid(request_t r);
    if (r.year == 0 || r.year > cal_max_year) return 0;
    if (r.month < 1 || r.month > 12) return 0;
    if (r.day < 1 || r.day > days_in_month(r.month - 1)) return 0;
    if (r.hour > 23 || r.minute > 59 || r.second > 59) return 0;
    return 1;
  endfunction

  function automatic longint unsigned seconds_since_origin(int unsigned y, int unsigned mo,
                                                           int unsigned d, int unsigned h,
                                                           int unsigned mi, int unsigned s);
    int unsigned idx;
    longint unsigned doy;
    idx = (mo >= 1 && mo <= 12) ? mo - 1 : 0;
    doy = first_day_of(idx) + d - 1;
    return (longint'(y) * 365 + doy) * 86400 + h * 3600 + mi * 60 + s;
  endfunction

  // advance by whole days and install a new time of day; 0 on year overflow
  function automatic bit advance_days(longint unsigned days, longint unsigned tod);
    longint unsigned total, y, doy;
    int unsigned m;
    total = first_day_of(cal_month - 1) + cal_day - 1 + days;
    y = cal_year + total / 365;
    doy = total % 365;
    if (y > cal_max_year) return 0;
    m = 0;
    while (m < 11 && doy >= first_day_of(m + 1)) m++;
    cal_year   = y;
    cal_month  = m + 1;
    cal_day    = doy - first_day_of(m) + 1;
    cal_hour   = tod / 3600;
    cal_minute = (tod / 60) % 60;
    cal_second = tod % 60;
    return 1;
  endfunction

  function automatic bit advance_months(longint unsigned months);
    longint unsigned m0, y;
    int unsigned m;
    m0 = cal_month - 1 + months;
    y = cal_year + m0 / 12;
    m = m0 % 12;
    if (y > cal_max_year) return 0;
    cal_year = y;
    cal_month = m + 1;
    if (cal_day > days_in_month(m)) cal_day = days_in_month(m);
    return 1;
  endfunction

  function automatic moment_result_t predict_moment(request_t r);
    moment_result_t res;
    longint unsigned tod, t, a, b, span;
    bit ok;
    span = 0;
    ok = 1;
    tod = cal_hour * 3600 + cal_minute * 60 + cal_second;
    case (r.kind)
      cdta_pkg::KIND_LOAD: begin
        ok = moment_valid(r);
        if (ok) begin
          cal_year = r.year; cal_month = r.month; cal_day = r.day;
          cal_hour = r.hour; cal_minute = r.minute; cal_second = r.second;
        end
      end
      cdta_pkg::KIND_SECONDS, cdta_pkg::KIND_MINUTES, cdta_pkg::KIND_HOURS: begin
        t = tod + longint'(r.amount) * ((r.kind == cdta_pkg::KIND_SECONDS) ? 1 :
                                        (r.kind == cdta_pkg::KIND_MINUTES) ? 60 : 3600);
        ok = advance_days(t / 86400, t % 86400);
      end
      cdta_pkg::KIND_DAYS:   ok = advance_days(r.amount, tod);
      cdta_pkg::KIND_MONTHS: ok = advance_months(r.amount);
      cdta_pkg::KIND_YEARS:  ok = advance_months(longint'(r.amount) * 12);
      default: begin
        ok = moment_valid(r);
        if (ok) begin
          a = seconds_since_origin(cal_year, cal_month, cal_day, cal_hour, cal_minute,
                                   cal_second);
          b = seconds_since_origin(r.year, r.month, r.day, r.hour, r.minute, r.second);
          if (b < a) ok = 0;
          else span = b - a;
        end
      end
    endcase
    res.year   = cal_year;
    res.month  = cal_month;
    res.day    = cal_day;
    res.hour   = cal_hour;
    res.minute = cal_minute;
    res.second = cal_second;
    res.span   = span;
    res.err    = !ok;
    return res;
  endfunction

  // append a request to the driver's queue
  function automatic void queue_request(request_t r);
    pending_requests = {pending_requests, r};
  endfunction

  // clock: 2 ns period
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // request driver: inputs move at the falling edge, one transaction at a time
  bit in_accepted;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_accepted) begin
        kind_hits[kind]++;
        expected_moments = {expected_moments, predict_moment(pending_requests.pop_front())};
      end
      if (!in_valid || in_accepted) begin
        if (pending_requests.size() > 0 && (idle_free || $urandom_range(99) >= 19)) begin
          in_valid     <= 1'b1;
          kind         <= pending_requests[0].kind;
          amount       <= pending_requests[0].amount;
          given_year   <= pending_requests[0].year;
          given_month  <= pending_requests[0].month;
          given_day    <= pending_requests[0].day;
          given_hour   <= pending_requests[0].hour;
          given_minute <= pending_requests[0].minute;
          given_second <= pending_requests[0].second;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // acceptance is sampled at the rising edge, acted on at the next falling edge
  always @(posedge clk) in_accepted <= in_valid && !in_stall;

  // receiver stall, with a long hold-off counted here
  always @(negedge clk) begin
    if (rst) begin
      out_stall   <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_request && hold_cycles == 0) begin
      hold_cycles <= 400;
      out_stall   <= 1'b1;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      hold_cycles <= 0;
      out_stall   <= !idle_free && ($urandom_range(99) < 19);
    end
  end

  // result monitor: compare each accepted transaction to the oldest prediction
  always @(posedge clk) begin
    moment_result_t exp_m;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_moments.size() == 0) begin
        $display("%0t: result with nothing expected (year %0d)", $time, out_year);
        error_count++;
      end else begin
        exp_m = expected_moments.pop_front();
        if (exp_m.err) errors_seen++;
        if (exp_m.span != 0) spans_seen++;
        if (out_year !== exp_m.year) begin
          $display("%0t: out_year expected %0d actual %0d", $time, exp_m.year, out_year);
          error_count++;
        end
        if (out_month !== exp_m.month) begin
          $display("%0t: out_month expected %0d actual %0d", $time, exp_m.month, out_month);
          error_count++;
        end
        if (out_day !== exp_m.day) begin
          $display("%0t: out_day expected %0d actual %0d", $time, exp_m.day, out_day);
          error_count++;
        end
        if (out_hour !== exp_m.hour) begin
          $display("%0t: out_hour expected %0d actual %0d", $time, exp_m.hour, out_hour);
          error_count++;
        end
        if (out_minute !== exp_m.minute) begin
          $display("%0t: out_minute expected %0d actual %0d", $time, exp_m.minute,
                   out_minute);
          error_count++;
        end
        if (out_second !== exp_m.second) begin
          $display("%0t: out_second expected %0d actual %0d", $time, exp_m.second,
                   out_second);
          error_count++;
        end
        if (span_seconds !== exp_m.span) begin
          $display("%0t: span_seconds expected %0d actual %0d", $time, exp_m.span,
                   span_seconds);
          error_count++;
        end
        if (error !== exp_m.err) begin
          $display("%0t: error expected %0b actual %0b", $time, exp_m.err, error);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_moments.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic request_t make_request(cdta_pkg::kind_t k, logic [31:0] amt,
                                            int unsigned y, int unsigned mo,
                                            int unsigned d, int unsigned h,
                                            int unsigned mi, int unsigned s);
    request_t r;
    r.kind = k; r.amount = amt;
    r.year = y; r.month = mo; r.day = d; r.hour = h; r.minute = mi; r.second = s;
    return r;
  endfunction

  // mostly valid moments with years up to the limit, sometimes arbitrary bits
  function automatic request_t random_moment(cdta_pkg::kind_t k, int unsigned lim);
    request_t r;
    int unsigned mo;
    if ($urandom_range(99) < 12) begin
      r = make_request(k, $urandom, $urandom_range(16383), $urandom_range(15),
                       $urandom_range(31), $urandom_range(31), $urandom_range(63),
                       $urandom_range(63));
    end else begin
      mo = $urandom_range(12, 1);
      r = make_request(k, $urandom, $urandom_range((lim > 0) ? lim : 1, 1), mo,
                       $urandom_range(days_in_month(mo - 1), 1), $urandom_range(23),
                       $urandom_range(59), $urandom_range(59));
    end
    return r;
  endfunction

  function automatic request_t random_request(int unsigned lim);
    request_t r;
    cdta_pkg::kind_t k;
    k = cdta_pkg::kind_t'($urandom_range(7));
    if (k == cdta_pkg::KIND_LOAD || k == cdta_pkg::KIND_SPAN) return random_moment(k, lim);
    r = random_moment(k, lim);
    // amounts: mostly modest, sometimes the full 32-bit range
    case ($urandom_range(3))
      0:       r.amount = $urandom;
      1:       r.amount = $urandom_range(1_000_000);
      default: r.amount = $urandom_range(400);
    endcase
    if (k == cdta_pkg::KIND_YEARS && $urandom_range(3) != 0) r.amount = $urandom_range(30);
    return r;
  endfunction

  task automatic wait_drained();
    while (pending_requests.size() > 0 || expected_moments.size() > 0 || in_valid)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_max_year(logic [13:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cal_max_year = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    request_t r;
    int unsigned phase_limit[5];
    rst          = 1'b1;
    in_valid     = 1'b0;
    out_stall    = 1'b0;
    in_accepted  = 1'b0;
    kind         = cdta_pkg::KIND_LOAD;
    amount       = '0;
    given_year   = '0;
    given_month  = '0;
    given_day    = '0;
    given_hour   = '0;
    given_minute = '0;
    given_second = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    cycle_count  = 0;
    error_count  = 0;
    idle_free    = 0;
    hold_request = 0;
    cal_max_year = cdta_pkg::MAX_YEAR_RESET;
    cal_year = 1; cal_month = 1; cal_day = 1;
    cal_hour = 0; cal_minute = 0; cal_second = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every kind, each special case, under the reset limit
    queue_request(make_request(cdta_pkg::KIND_SECONDS, 0, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 2023, 1, 31, 23, 59, 59));
    queue_request(make_request(cdta_pkg::KIND_SECONDS, 1, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_MINUTES, 1441, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_HOURS, 25, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_DAYS, 365, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 2024, 1, 31, 12, 0, 0));
    // short month clamp, month and year carry
    queue_request(make_request(cdta_pkg::KIND_MONTHS, 1, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_MONTHS, 13, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_YEARS, 7, 0, 0, 0, 0, 0, 0));
    // invalid moments
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 0, 1, 1, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 10000, 1, 1, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 100, 2, 29, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 100, 13, 1, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 100, 1, 1, 24, 60, 60));
    queue_request(make_request(cdta_pkg::KIND_SPAN, 0, 16383, 15, 31, 31, 63, 63));
    // measure: later, equal, earlier target
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 1, 1, 1, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_SPAN, 0, 9999, 12, 31, 23, 59, 59));
    queue_request(make_request(cdta_pkg::KIND_SPAN, 0, 1, 1, 1, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_LOAD, 0, 500, 6, 15, 6, 30, 30));
    queue_request(make_request(cdta_pkg::KIND_SPAN, 0, 499, 6, 15, 6, 30, 30));
    // largest amounts: add years and add hours overflow the year, add seconds carries years
    queue_request(make_request(cdta_pkg::KIND_YEARS, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_HOURS, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(cdta_pkg::KIND_SECONDS, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
    wait_drained();

    // random phases under several limits, extremes among them
    phase_limit = '{16383, 1, 9999, 0, 60};
    foreach (phase_limit[p]) begin
      write_max_year(phase_limit[p]);
      for (int i = 0; i < ((p == 3) ? 60 : RANDOM_ITEMS / 4); i++) begin
        r = random_request(phase_limit[p]);
        queue_request(r);
      end
      if (p == 0) begin
        // no idling for a stretch, then a long receiver hold-off
        idle_free = 1;
        while (pending_requests.size() > RANDOM_ITEMS / 8) @(posedge clk);
        idle_free = 0;
        hold_request = 1;
        @(posedge clk);
        while (hold_cycles == 0) @(posedge clk);
        hold_request = 0;
      end
      wait_drained();
      // limit lowered below the stored year: every add should now fail
      if (p == 2) begin
        write_max_year(1);
        queue_request(make_request(cdta_pkg::KIND_SECONDS, 5, 0, 0, 0, 0, 0, 0));
        queue_request(make_request(cdta_pkg::KIND_MONTHS, 0, 0, 0, 0, 0, 0, 0));
        wait_drained();
      end
    end

    $display("requests per kind: load %0d sec %0d min %0d hr %0d day %0d mon %0d",
             kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
             kind_hits[5]);
    $display("  yr %0d span %0d; %0d results checked, %0d rejected, %0d nonzero spans",
             kind_hits[6], kind_hits[7], results_seen, errors_seen, spans_seen);
    if (error_count == 0 && expected_moments.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
